@@ design/brc_pkg.sv @@
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types, register indexes and saturating helpers for the blit
// rectangle clipper.
// ----------------------------------------------------------------------------
package brc_pkg;

	localparam int CoordW = 24;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [2:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_CLIP_LEFT   = 3'd0;
	localparam cfg_idx_t REG_CLIP_TOP    = 3'd1;
	localparam cfg_idx_t REG_CLIP_RIGHT  = 3'd2;
	localparam cfg_idx_t REG_CLIP_BOTTOM = 3'd3;
	localparam cfg_idx_t REG_OFFSET_X    = 3'd4;
	localparam cfg_idx_t REG_OFFSET_Y    = 3'd5;

	// Reset values: a 1024.0 by 768.0 clip window, no translation.
	localparam coord_t CLIP_RIGHT_RST  = 24'sd262144;
	localparam coord_t CLIP_BOTTOM_RST = 24'sd196608;

	// One axis of a blit: near and far edges of destination and source.
	typedef struct packed {
		coord_t d_near;
		coord_t d_far;
		coord_t s_near;
		coord_t s_far;
		logic   bad;
	} axis_t;

	// Clamps a wide signed value into the coordinate range.
	function automatic coord_t sat24(input logic signed [27:0] v);
		coord_t r;
		if (v > 28'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -28'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// a - b without overflow.
	function automatic logic signed [24:0] diff25(input coord_t a, input coord_t b);
		logic signed [24:0] r;
		r = {a[23], a} - {b[23], b};
		return r;
	endfunction

endpackage

@@ design/brc_step.sv @@
// ----------------------------------------------------------------------------
// brc_step
// One clip step on one axis: cuts the near or far destination edge and moves
// the matching source edge by delta * source extent / destination extent.
// ----------------------------------------------------------------------------
module brc_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          far_side,
	input  brc_pkg::coord_t clip,
	input  logic          in_valid,
	input  brc_pkg::axis_t  in_ax,
	output logic          out_valid,
	output brc_pkg::axis_t  out_ax
);
	import brc_pkg::*;

	localparam int QW    = 25;      // quotient bits below the saturation limit
	localparam int NPIPE = 3 + QW;  // operand, product, range check, divide

	typedef struct packed {
		axis_t       ax;
		logic        fire;
		logic        zero;
		logic        neg;
		logic        ovf;
		logic [23:0] amag;
		logic [23:0] smag;
		logic [23:0] dmag;
		logic [47:0] rem;
		logic [QW-1:0] q;
	} st_t;

	st_t  pl_s [NPIPE];
	logic vl_s [NPIPE];
	st_t  nx   [NPIPE];

	axis_t fin;

	always_comb begin
		logic signed [24:0] delta;
		logic signed [24:0] sext;
		logic signed [24:0] dext;
		logic [48:0]        trial;
		nx[0]      = '0;
		nx[0].ax   = in_ax;
		sext       = diff25(in_ax.s_far, in_ax.s_near);
		dext       = diff25(in_ax.d_far, in_ax.d_near);
		if (far_side) begin
			nx[0].fire = in_ax.d_far > clip;
			delta      = diff25(in_ax.d_far, clip);
		end else begin
			nx[0].fire = in_ax.d_near < clip;
			delta      = diff25(clip, in_ax.d_near);
		end
		nx[0].amag = delta[23:0];
		nx[0].smag = sext[24] ? 24'(-sext) : sext[23:0];
		nx[0].dmag = dext[24] ? 24'(-dext) : dext[23:0];
		nx[0].neg  = sext[24] ^ dext[24];
		nx[0].zero = dext == 25'sd0;

		nx[1]     = pl_s[0];
		nx[1].rem = pl_s[0].amag * pl_s[0].smag;

		// A quotient of 2^25 or more saturates the source edge anyway.
		nx[2]     = pl_s[1];
		nx[2].ovf = {1'b0, pl_s[1].rem} >= {pl_s[1].dmag, 25'b0};

		trial = '0;
		for (int k = 0; k < QW; k++) begin
			nx[3+k] = pl_s[2+k];
			trial   = {1'b0, pl_s[2+k].rem} - ({25'b0, pl_s[2+k].dmag} << (QW-1-k));
			if (!trial[48]) begin
				nx[3+k].rem          = trial[47:0];
				nx[3+k].q[QW-1-k]    = 1'b1;
			end
		end
	end

	always_comb begin
		st_t                l;
		logic [25:0]        mag;
		logic signed [27:0] qv;
		logic signed [27:0] sum;
		l   = pl_s[NPIPE-1];
		mag = l.ovf ? 26'h2000000 : {1'b0, l.q};
		qv  = l.neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
		if (!l.fire || l.zero) begin
			qv = '0;
		end
		fin = l.ax;
		if (far_side) begin
			sum = {{4{l.ax.s_far[23]}}, l.ax.s_far} - qv;
		end else begin
			sum = {{4{l.ax.s_near[23]}}, l.ax.s_near} + qv;
		end
		if (l.fire) begin
			if (far_side) begin
				fin.d_far = clip;
				fin.s_far = sat24(sum);
			end else begin
				fin.d_near = clip;
				fin.s_near = sat24(sum);
			end
			fin.bad = l.ax.bad | l.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NPIPE; j++) begin
				pl_s[j] <= nx[j];
			end
			out_ax <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NPIPE; j++) begin
				vl_s[j] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			vl_s[0] <= in_valid;
			for (int j = 1; j < NPIPE; j++) begin
				vl_s[j] <= vl_s[j-1];
			end
			out_valid <= vl_s[NPIPE-1];
		end
	end

endmodule

@@ design/blit_rect_clip_with_source_adjust.sv @@
// ----------------------------------------------------------------------------
// blit_rect_clip_with_source_adjust
// Translates a blit destination, clips it left, top, right, bottom and
// moves the source edges in proportion.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Contents
// in        sink       in_valid / in_ready    destination and source edges
// out       source     out_valid / out_ready  visible flag, clipped rectangles
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command is accepted every cycle unless stalled; a command passes the
// translation stage, the two clip steps and the result stage in turn.
// The depth is set by the two long dividers in series, one quotient bit a
// stage. All stages advance together whenever the result register is empty
// or being taken, so a stall freezes the whole pipeline and nothing is lost.
// Reset clears the valid bits and loads the register reset values; the
// configuration port is always ready.
//
module blit_rect_clip_with_source_adjust (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  brc_pkg::coord_t dest_left,
	input  brc_pkg::coord_t dest_top,
	input  brc_pkg::coord_t dest_right,
	input  brc_pkg::coord_t dest_bottom,
	input  brc_pkg::coord_t src_left,
	input  brc_pkg::coord_t src_top,
	input  brc_pkg::coord_t src_right,
	input  brc_pkg::coord_t src_bottom,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            visible,
	output brc_pkg::coord_t out_dest_left,
	output brc_pkg::coord_t out_dest_top,
	output brc_pkg::coord_t out_dest_right,
	output brc_pkg::coord_t out_dest_bottom,
	output brc_pkg::coord_t out_src_left,
	output brc_pkg::coord_t out_src_top,
	output brc_pkg::coord_t out_src_right,
	output brc_pkg::coord_t out_src_bottom,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  brc_pkg::cfg_idx_t cfg_index,
	input  brc_pkg::coord_t cfg_data
);
	import brc_pkg::*;

	coord_t clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	coord_t offset_x_q, offset_y_q;

	// The pipeline moves as one; it only halts when a finished result is
	// still waiting to be taken.
	logic en;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// Register writes; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= CLIP_RIGHT_RST;
			clip_bottom_q <= CLIP_BOTTOM_RST;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:   clip_left_q   <= cfg_data;
				REG_CLIP_TOP:    clip_top_q    <= cfg_data;
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_data;
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data;
				REG_OFFSET_X:    offset_x_q    <= cfg_data;
				REG_OFFSET_Y:    offset_y_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Translation stage: each destination edge is shifted by the offset and
	// saturated to the coordinate range.
	axis_t h_s1, v_s1;
	logic  vld_s1;

	function automatic coord_t add_sat(input coord_t a, input coord_t b);
		return sat24({{4{a[23]}}, a} + {{4{b[23]}}, b});
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1.d_near <= add_sat(dest_left, offset_x_q);
			h_s1.d_far  <= add_sat(dest_right, offset_x_q);
			h_s1.s_near <= src_left;
			h_s1.s_far  <= src_right;
			h_s1.bad    <= 1'b0;
			v_s1.d_near <= add_sat(dest_top, offset_y_q);
			v_s1.d_far  <= add_sat(dest_bottom, offset_y_q);
			v_s1.s_near <= src_top;
			v_s1.s_far  <= src_bottom;
			v_s1.bad    <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// The horizontal and vertical axes are independent, so they run side by
	// side: left then right on one lane, top then bottom on the other.
	axis_t h_mid, v_mid, h_end, v_end;
	logic  hv_mid, vv_mid, hv_end, vv_end;

	brc_step u_left (
		.clk(clk), .arst_n(arst_n), .en(en), .far_side(1'b0), .clip(clip_left_q),
		.in_valid(vld_s1), .in_ax(h_s1), .out_valid(hv_mid), .out_ax(h_mid)
	);

	brc_step u_top (
		.clk(clk), .arst_n(arst_n), .en(en), .far_side(1'b0), .clip(clip_top_q),
		.in_valid(vld_s1), .in_ax(v_s1), .out_valid(vv_mid), .out_ax(v_mid)
	);

	brc_step u_right (
		.clk(clk), .arst_n(arst_n), .en(en), .far_side(1'b1), .clip(clip_right_q),
		.in_valid(hv_mid), .in_ax(h_mid), .out_valid(hv_end), .out_ax(h_end)
	);

	brc_step u_bottom (
		.clk(clk), .arst_n(arst_n), .en(en), .far_side(1'b1), .clip(clip_bottom_q),
		.in_valid(vv_mid), .in_ax(v_mid), .out_valid(vv_end), .out_ax(v_end)
	);

	// Result stage: the visible flag needs all four extents positive and no
	// cut made against a zero-width destination.
	logic vis_c;
	assign vis_c = !h_end.bad && !v_end.bad &&
	               (diff25(h_end.d_far, h_end.d_near) > 25'sd0) &&
	               (diff25(v_end.d_far, v_end.d_near) > 25'sd0) &&
	               (diff25(h_end.s_far, h_end.s_near) > 25'sd0) &&
	               (diff25(v_end.s_far, v_end.s_near) > 25'sd0);

	always_ff @(posedge clk) begin
		if (en) begin
			visible         <= vis_c;
			out_dest_left   <= h_end.d_near;
			out_dest_right  <= h_end.d_far;
			out_src_left    <= h_end.s_near;
			out_src_right   <= h_end.s_far;
			out_dest_top    <= v_end.d_near;
			out_dest_bottom <= v_end.d_far;
			out_src_top     <= v_end.s_near;
			out_src_bottom  <= v_end.s_far;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= hv_end;
		end
	end

`ifndef SYNTHESIS
	// Both lanes must carry the same command after each clip step.
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(hv_end == vv_end) && (hv_mid == vv_mid))
		else $error("horizontal and vertical lanes out of step");

	// A visible result has a positive destination.
	a_vis_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && visible) |->
		(out_dest_right > out_dest_left) && (out_dest_bottom > out_dest_top))
		else $error("visible result with empty destination");

	// A visible result has a positive source.
	a_vis_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && visible) |->
		(out_src_right > out_src_left) && (out_src_bottom > out_src_top))
		else $error("visible result with empty source");

	// A stalled result register holds its valid, visible flag and left destination edge.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_dest_left) && $stable(visible))
		else $error("result changed while stalled");
`endif

endmodule
